@@ rtl/fpa_pkg.sv @@
// Shared types, op codes and constants for the Q24.8 fixed-point ALU.
`timescale 1ns / 1ps
`default_nettype none
package fpa_pkg;

  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned FRAC_BITS = 8;
  localparam int unsigned DIV_BITS  = WORD_BITS + FRAC_BITS;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_BITS);

  typedef enum logic [4:0] {
    OP_ADD        = 5'd0,
    OP_SUB        = 5'd1,
    OP_MUL        = 5'd2,
    OP_DIV        = 5'd3,
    OP_GT         = 5'd4,
    OP_LT         = 5'd5,
    OP_GE         = 5'd6,
    OP_LE         = 5'd7,
    OP_EQ         = 5'd8,
    OP_NE         = 5'd9,
    OP_MIN        = 5'd10,
    OP_MAX        = 5'd11,
    OP_INC        = 5'd12,
    OP_DEC        = 5'd13,
    OP_FROM_INT   = 5'd14,
    OP_TO_INT     = 5'd15,
    OP_FROM_FLOAT = 5'd16,
    OP_TO_FLOAT   = 5'd17
  } fpa_op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OVF  = 2'd1,
    ST_DIV0 = 2'd2,
    ST_INV  = 2'd3
  } fpa_status_e;

  typedef enum logic [1:0] {
    CLS_SIMPLE = 2'd0,
    CLS_MUL    = 2'd1,
    CLS_DIV    = 2'd2,
    CLS_FLT    = 2'd3
  } fpa_cls_e;

  typedef struct packed {
    logic [4:0]         op;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } fpa_in_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic [1:0]         status;
  } fpa_out_t;

  typedef struct packed {
    fpa_cls_e cls;
    fpa_in_t  data;
  } fpa_item_t;

endpackage
`default_nettype wire

@@ rtl/fpa_queue.sv @@
// Two-entry queue between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module fpa_queue
  import fpa_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_valid_i,
  output logic           push_ready_o,
  input  wire fpa_item_t push_item_i,
  output logic           pop_valid_o,
  input  wire logic      pop_ready_i,
  output fpa_item_t      pop_item_o
);

  fpa_item_t  mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      unique case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/fpa_front.sv @@
// Front end: takes input transfers and tags each with its execution class.
`timescale 1ns / 1ps
`default_nettype none
module fpa_front
  import fpa_pkg::*;
(
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire fpa_in_t in_i,
  output logic         push_valid_o,
  input  wire logic    push_ready_i,
  output fpa_item_t    push_item_o
);

  fpa_cls_e cls;

  always_comb begin
    unique case (in_i.op)
      OP_MUL:      cls = CLS_MUL;
      OP_DIV:      cls = CLS_DIV;
      OP_TO_FLOAT: cls = CLS_FLT;
      default:     cls = CLS_SIMPLE;
    endcase
  end

  assign in_ready_o       = push_ready_i;
  assign push_valid_o     = in_valid_i;
  assign push_item_o.cls  = cls;
  assign push_item_o.data = in_i;

endmodule
`default_nettype wire

@@ rtl/fpa_div.sv @@
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module fpa_div
  import fpa_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [DIV_BITS-1:0] dividend_i,
  input  wire logic [31:0]         divisor_i,
  output logic                     busy_o,
  output logic [DIV_BITS-1:0]      quot_o
);

  logic [DIV_BITS-1:0]  dq_q;
  logic [31:0]          rem_q, dsr_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q;
  logic [32:0]          rem_sh, rem_sub;
  logic                 qbit;

  // dq_q shifts dividend bits out the top and quotient bits in the bottom
  assign rem_sh  = {rem_q, dq_q[DIV_BITS-1]};
  assign rem_sub = rem_sh - {1'b0, dsr_q};
  assign qbit    = (rem_sh >= {1'b0, dsr_q});
  assign busy_o  = busy_q;
  assign quot_o  = dq_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      dq_q  <= {dq_q[DIV_BITS-2:0], qbit};
      rem_q <= qbit ? rem_sub[31:0] : rem_sh[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIV_BITS - 1)) busy_q <= 1'b0;
    end
  end

endmodule
`default_nettype wire

@@ rtl/fpa_back.sv @@
// Back end: executes queued items and holds the output register.
`timescale 1ns / 1ps
`default_nettype none
module fpa_back
  import fpa_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      pop_valid_i,
  output logic           pop_ready_o,
  input  wire fpa_item_t pop_item_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output fpa_out_t       out_o
);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_FLT, S_DIV} state_e;

  state_e              state_q;
  logic                out_valid_q;
  fpa_out_t            out_q;
  logic signed [63:0]  prod_q;
  logic [31:0]         fl_mag_q;
  logic                fl_sgn_q;
  logic [4:0]          fl_p_q;
  logic                neg_q;

  logic                slot_free, issue, fin, div_start, div_busy;
  logic signed [31:0]  a, b;
  logic [31:0]         ua, ub, ma, mb;
  fpa_out_t            simple_res, fin_res;
  logic [DIV_BITS-1:0] quot;

  assign a         = pop_item_i.data.operand_a;
  assign b         = pop_item_i.data.operand_b;
  assign ua        = a;
  assign ub        = b;
  assign ma        = ua[31] ? 32'(-ua) : ua;
  assign mb        = ub[31] ? 32'(-ub) : ub;
  assign slot_free = !out_valid_q || out_ready_i;
  assign issue     = (state_q == S_IDLE) && pop_valid_i && slot_free;
  assign pop_ready_o = issue;
  assign div_start = issue && (pop_item_i.cls == CLS_DIV) && (ub != '0);

  fpa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({ma, {FRAC_BITS{1'b0}}}),
    .divisor_i  (mb),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  // ops computed combinationally at issue, float-to-fixed included
  logic [31:0] sum, diff, ff_mag, ff_lim, sat;
  logic        ff_sat;
  logic [7:0]  ex;
  logic [23:0] mant;
  logic [8:0]  e9, sh;
  logic [25:0] rnd;

  always_comb begin
    sum  = ua + ub;
    diff = ua - ub;
    sat  = ua[31] ? 32'h8000_0000 : 32'h7fff_ffff;
    ex   = ua[30:23];
    mant = {(ex != 8'd0), ua[22:0]};
    e9   = (ex == 8'd0) ? 9'd1 : {1'b0, ex};
    ff_sat = 1'b0;
    ff_mag = '0;
    sh     = '0;
    rnd    = '0;
    if (ex == 8'hff) begin
      ff_sat = 1'b1;
    end else if (e9 >= 9'd142) begin
      sh = e9 - 9'd142;
      if (sh > 9'd8) ff_sat = 1'b1;
      else ff_mag = {8'd0, mant} << sh[3:0];
    end else begin
      sh = 9'd142 - e9;
      if (sh <= 9'd25) begin
        rnd    = ({2'b0, mant} + (26'd1 << (sh[4:0] - 5'd1))) >> sh[4:0];
        ff_mag = {6'd0, rnd};
      end
    end
    ff_lim = ua[31] ? 32'h8000_0000 : 32'h7fff_ffff;
    if (ff_mag > ff_lim) ff_sat = 1'b1;

    simple_res.status = ST_OK;
    simple_res.result = '0;
    unique case (pop_item_i.data.op)
      OP_ADD: begin
        simple_res.result = sum;
        if (ua[31] == ub[31] && sum[31] != ua[31]) simple_res.status = ST_OVF;
      end
      OP_SUB: begin
        simple_res.result = diff;
        if (ua[31] != ub[31] && diff[31] != ua[31]) simple_res.status = ST_OVF;
      end
      OP_GT:  simple_res.result = {31'd0, (a > b)};
      OP_LT:  simple_res.result = {31'd0, (a < b)};
      OP_GE:  simple_res.result = {31'd0, (a >= b)};
      OP_LE:  simple_res.result = {31'd0, (a <= b)};
      OP_EQ:  simple_res.result = {31'd0, (a == b)};
      OP_NE:  simple_res.result = {31'd0, (a != b)};
      OP_MIN: simple_res.result = (b < a) ? b : a;
      OP_MAX: simple_res.result = (a < b) ? b : a;
      OP_INC: begin
        simple_res.result = ua + 32'd1;
        if (ua == 32'h7fff_ffff) simple_res.status = ST_OVF;
      end
      OP_DEC: begin
        simple_res.result = ua - 32'd1;
        if (ua == 32'h8000_0000) simple_res.status = ST_OVF;
      end
      OP_FROM_INT: begin
        simple_res.result = ua << FRAC_BITS;
        if (!((&ua[31:31-FRAC_BITS]) || !(|ua[31:31-FRAC_BITS])))
          simple_res.status = ST_OVF;
      end
      OP_TO_INT: simple_res.result = a >>> FRAC_BITS;
      OP_FROM_FLOAT: begin
        if (ff_sat) begin
          simple_res.result = sat;
          simple_res.status = ST_INV;
        end else begin
          simple_res.result = ua[31] ? 32'(-ff_mag) : ff_mag;
        end
      end
      default: simple_res.result = '0;
    endcase
  end

  // leading one of the to_float magnitude, registered for the second stage
  logic [4:0] lead;
  always_comb begin
    lead = '0;
    for (int i = 0; i < 32; i++) begin
      if (ma[i]) lead = 5'(i);
    end
  end

  // second stages and final result selection
  logic [31:0] q_res, tf_res;
  logic        q_ovf;
  logic [23:0] tq;
  logic [24:0] tq_r;
  logic [7:0]  tk, rem, half, tp;

  always_comb begin
    q_ovf = (quot[DIV_BITS-1:32] != '0) ||
            (quot[31:0] > (neg_q ? 32'h8000_0000 : 32'h7fff_ffff));
    q_res = neg_q ? 32'(-quot[31:0]) : quot[31:0];

    tp   = {3'd0, fl_p_q};
    tk   = '0;
    rem  = '0;
    half = '0;
    tq   = '0;
    tq_r = '0;
    if (fl_p_q <= 5'd23) begin
      tq_r = {1'b0, 24'(fl_mag_q << (5'd23 - fl_p_q))};
    end else begin
      tk   = tp - 8'd23;
      rem  = 8'(fl_mag_q & ((32'd1 << tk[3:0]) - 32'd1));
      half = 8'd1 << (tk[3:0] - 4'd1);
      tq   = 24'(fl_mag_q >> tk[3:0]);
      tq_r = {1'b0, tq};
      if (rem > half || (rem == half && tq[0])) tq_r = tq_r + 25'd1;
      if (tq_r[24]) begin
        tq_r = tq_r >> 1;
        tp   = tp + 8'd1;
      end
    end
    if (fl_mag_q == '0) tf_res = '0;
    else tf_res = {fl_sgn_q, 8'(tp + 8'd127 - 8'(FRAC_BITS)), tq_r[22:0]};

    fin     = 1'b0;
    fin_res = simple_res;
    unique case (state_q)
      S_IDLE: begin
        if (issue && pop_item_i.cls == CLS_SIMPLE) fin = 1'b1;
        if (issue && pop_item_i.cls == CLS_DIV && ub == '0) begin
          fin = 1'b1;
          fin_res.result = '0;
          fin_res.status = ST_DIV0;
        end
      end
      S_MUL: begin
        fin = slot_free;
        fin_res.result = prod_q[39:8];
        fin_res.status = ((&prod_q[63:39]) || !(|prod_q[63:39])) ? ST_OK : ST_OVF;
      end
      S_FLT: begin
        fin = slot_free;
        fin_res.result = tf_res;
        fin_res.status = ST_OK;
      end
      S_DIV: begin
        fin = slot_free && !div_busy;
        fin_res.result = q_res;
        fin_res.status = q_ovf ? ST_OVF : ST_OK;
      end
      default: fin = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      prod_q   <= a * b;
      fl_mag_q <= ma;
      fl_sgn_q <= ua[31];
      fl_p_q   <= lead;
      neg_q    <= ua[31] ^ ub[31];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (fin) begin
        out_valid_q <= 1'b1;
        out_q       <= fin_res;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (issue) begin
            unique case (pop_item_i.cls)
              CLS_MUL: state_q <= S_MUL;
              CLS_FLT: state_q <= S_FLT;
              CLS_DIV: state_q <= (ub != '0) ? S_DIV : S_IDLE;
              default: state_q <= S_IDLE;
            endcase
          end
        end
        default: if (fin) state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule
`default_nettype wire

@@ rtl/fixed_point_q24_8_alu.sv @@
// Q24.8 fixed-point ALU top level: front end, queue and back end.
// Items enter through a valid/ready channel into a two-entry queue, and
// results leave from a registered output stage, so the input keeps taking
// transfers while a result waits. Add, sub, compares, min/max, inc/dec and
// the integer and float-to-fixed conversions finish at issue and issue back
// to back while the output register is free. Multiply and fixed-to-float
// finish in a second state, after a registered 32x32 product or a registered
// leading-one position. Divide issues, then its restoring divider retires
// one of the 40 quotient bits per cycle, then it finishes; it holds the back
// end meanwhile. Divide by zero finishes at issue, without the divider.
`timescale 1ns / 1ps
`default_nettype none
module fixed_point_q24_8_alu
  import fpa_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire fpa_in_t in_i,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output fpa_out_t     out_o
);

  logic      push_valid, push_ready, pop_valid, pop_ready;
  fpa_item_t push_item, pop_item;

  fpa_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  fpa_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  fpa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_item_i  (pop_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule
`default_nettype wire

@@ rtl/fpa_checker.sv @@
// Port-level checker for the fixed-point ALU, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module fpa_checker
  import fpa_pkg::*;
(
  input wire logic    clk_i,
  input wire logic    rst_ni,
  input wire logic    in_valid_i,
  input wire logic    in_ready_o,
  input wire fpa_in_t in_i,
  input wire logic    out_valid_o,
  input wire logic    out_ready_i,
  input wire fpa_out_t out_o
);

  // transfers in flight: queue, back end and output register
  logic [2:0] pend_q;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + {2'd0, in_xfer} - {2'd0, out_xfer};
    end
  end

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_i))
    else $error("input changed while stalled");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("output changed while stalled");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 3'd0)
    else $error("result without an outstanding item");

  a_div0_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.status == ST_DIV0 |-> out_o.result == '0)
    else $error("divide by zero gave a non-zero result");

  a_inv_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.status == ST_INV |->
      out_o.result == 32'sh7fff_ffff || out_o.result == 32'sh8000_0000)
    else $error("invalid float did not saturate");

endmodule

bind fixed_point_q24_8_alu fpa_checker u_fpa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_i        (in_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_o       (out_o)
);
`default_nettype wire

@@ tb/fixed_point_q24_8_alu_tb.sv @@
// Self-checking testbench for the Q24.8 fixed-point ALU: directed table, then random ops.
`timescale 1ns / 1ps
module fixed_point_q24_8_alu_tb;
  import fpa_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1600;
  localparam int unsigned IDLE_LIMIT   = 2000;

  typedef struct packed {
    logic     known;
    fpa_in_t  stim;
    fpa_out_t res;
  } dir_row_t;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  fpa_in_t  in_i;
  logic     out_valid_o;
  logic     out_ready_i;
  fpa_out_t out_o;

  fpa_out_t   alu_expected_q[$];
  dir_row_t   dir_rows[$];
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned idle_cycles;
  int unsigned op_hits[18];
  bit          stim_done;

  fixed_point_q24_8_alu DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Double-width multiply, rescaled; flags when the shifted product does not fit a word.
  function automatic fpa_out_t q_mul(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [63:0] p;
    logic signed [63:0] s;
    fpa_out_t r;
    p = 64'(a) * 64'(b);
    s = p >>> FRAC_BITS;
    r.result = s[31:0];
    r.status = (s != 64'(signed'(s[31:0]))) ? ST_OVF : ST_OK;
    return r;
  endfunction

  function automatic fpa_out_t q_div(logic signed [31:0] a, logic signed [31:0] b);
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] q;
    logic        neg;
    fpa_out_t    r;
    if (b == 0) begin
      r.result = '0;
      r.status = ST_DIV0;
      return r;
    end
    neg = a[31] ^ b[31];
    ma = a[31] ? -64'(a) : 64'(a);
    mb = b[31] ? -64'(b) : 64'(b);
    q = (ma << FRAC_BITS) / mb;
    r.result = neg ? 32'(-q) : q[31:0];
    r.status = (q > (neg ? 64'h8000_0000 : 64'h7fff_ffff)) ? ST_OVF : ST_OK;
    return r;
  endfunction

  // Float bits to fixed, round half away from zero, saturating.
  function automatic fpa_out_t q_from_float(logic [31:0] u);
    logic [7:0]  ex;
    logic [63:0] m;
    logic [63:0] mag;
    logic [63:0] lim;
    int          s;
    fpa_out_t    r;
    ex = u[30:23];
    m = {40'd0, u[22:0]};
    lim = u[31] ? 64'h8000_0000 : 64'h7fff_ffff;
    r.status = ST_OK;
    if (ex == 8'hff) begin
      r.result = u[31] ? 32'h8000_0000 : 32'h7fff_ffff;
      r.status = ST_INV;
      return r;
    end
    if (ex != 0) m[23] = 1'b1;
    if (m == 0) begin
      r.result = '0;
      return r;
    end
    s = int'(ex == 0 ? 8'd1 : ex) - 150 + FRAC_BITS;
    if (s > 40) begin
      r.result = u[31] ? 32'h8000_0000 : 32'h7fff_ffff;
      r.status = ST_INV;
      return r;
    end
    if (s >= 0) mag = m << s;
    else if (-s > 25) mag = '0;
    else mag = (m + (64'd1 << (-s - 1))) >> (-s);
    if (mag > lim) begin
      r.result = u[31] ? 32'h8000_0000 : 32'h7fff_ffff;
      r.status = ST_INV;
    end else begin
      r.result = u[31] ? 32'(-mag) : mag[31:0];
    end
    return r;
  endfunction

  // Fixed to single, round to nearest even.
  function automatic logic [31:0] q_to_float(logic signed [31:0] a);
    logic [31:0] mag;
    logic [31:0] q;
    logic [31:0] rem;
    logic [31:0] half;
    int          p;
    int          k;
    mag = a[31] ? -a : a;
    if (mag == 0) return '0;
    p = 0;
    for (int i = 0; i < 32; i++) if (mag[i]) p = i;
    if (p <= 23) begin
      q = mag << (23 - p);
    end else begin
      k = p - 23;
      rem = mag & ((32'd1 << k) - 1);
      half = 32'd1 << (k - 1);
      q = mag >> k;
      if (rem > half || (rem == half && q[0])) q++;
      if (q[24]) begin
        q = q >> 1;
        p++;
      end
    end
    return {a[31], 8'(p + 127 - FRAC_BITS), q[22:0]};
  endfunction

  function automatic fpa_out_t alu_predict(fpa_in_t t);
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] w;
    fpa_out_t           r;
    a = t.operand_a;
    b = t.operand_b;
    r.result = '0;
    r.status = ST_OK;
    case (t.op)
      OP_ADD: begin
        r.result = a + b;
        if (a[31] == b[31] && r.result[31] != a[31]) r.status = ST_OVF;
      end
      OP_SUB: begin
        r.result = a - b;
        if (a[31] != b[31] && r.result[31] != a[31]) r.status = ST_OVF;
      end
      OP_MUL:        r = q_mul(a, b);
      OP_DIV:        r = q_div(a, b);
      OP_GT:         r.result = 32'(a > b);
      OP_LT:         r.result = 32'(a < b);
      OP_GE:         r.result = 32'(a >= b);
      OP_LE:         r.result = 32'(a <= b);
      OP_EQ:         r.result = 32'(a == b);
      OP_NE:         r.result = 32'(a != b);
      OP_MIN:        r.result = (a > b) ? b : a;
      OP_MAX:        r.result = (a < b) ? b : a;
      OP_INC: begin
        r.result = a + 1;
        if (a == 32'sh7fff_ffff) r.status = ST_OVF;
      end
      OP_DEC: begin
        r.result = a - 1;
        if (a == 32'sh8000_0000) r.status = ST_OVF;
      end
      OP_FROM_INT: begin
        w = a <<< FRAC_BITS;
        r.result = w;
        if ((w >>> FRAC_BITS) != a) r.status = ST_OVF;
      end
      OP_TO_INT:     r.result = a >>> FRAC_BITS;
      OP_FROM_FLOAT: r = q_from_float(a);
      OP_TO_FLOAT:   r.result = q_to_float(a);
      default: ;
    endcase
    return r;
  endfunction

  function automatic dir_row_t row(fpa_op_e op, logic [31:0] a, logic [31:0] b, logic known,
                                   logic [31:0] res, fpa_status_e st);
    dir_row_t d;
    d.stim.op = op;
    d.stim.operand_a = a;
    d.stim.operand_b = b;
    d.known = known;
    d.res.result = res;
    d.res.status = st;
    return d;
  endfunction

  // Operand mix: mostly small fixed values, some extremes, some fully random.
  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0:       return $urandom();
      1:       return $urandom_range(0, 1) ? 32'h7fff_ffff - $urandom_range(0, 3)
                                           : 32'h8000_0000 + $urandom_range(0, 3);
      2:       return 32'($signed($urandom_range(0, 20)) - 10);
      default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    endcase
  endfunction

  function automatic logic [31:0] rand_float();
    logic [31:0] f;
    f = $urandom();
    case ($urandom_range(0, 3))
      0: f[30:23] = 8'hff;
      1: f[30:23] = 8'(118 + $urandom_range(0, 40));
      2: f[30:23] = $urandom_range(0, 1) ? 8'd0 : 8'(100 + $urandom_range(0, 60));
      default: ;
    endcase
    return f;
  endfunction

  task automatic send(fpa_in_t t);
    in_i <= t;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic gap();
    int unsigned n;
    in_valid_i <= 1'b0;
    n = $urandom_range(1, 4);
    repeat (n) @(negedge clk_i);
  endtask

  // Inputs are accounted on the rising edge when the transfer happens.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      alu_expected_q.push_back(alu_predict(in_i));
      if (in_i.op < 18) op_hits[in_i.op]++;
    end
  end

  // Directed rows with a known answer override the predictor for that slot.
  fpa_out_t known_q[$];
  logic     known_flag_q[$];

  always @(posedge clk_i) begin
    fpa_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (alu_expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h status %0d", out_o.result,
                                       out_o.status);
      end else begin
        want = alu_expected_q.pop_front();
        if (known_flag_q.size() != 0) begin
          if (known_flag_q.pop_front()) want = known_q.pop_front();
        end
        if (out_o.result !== want.result || out_o.status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch #%0d: expected %h/%0d, got %h/%0d", results_seen,
                     want.result, want.status, out_o.result, out_o.status);
        end
      end
    end
  end

  // Receiver: stall pattern of its own, with quiet stretches.
  always @(negedge clk_i) begin
    if (!rst_ni) out_ready_i <= 1'b0;
    else if (results_seen % 200 < 60) out_ready_i <= 1'b1;
    else out_ready_i <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else if (!stim_done || alu_expected_q.size() != 0) idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    fpa_in_t     t;
    int unsigned burst;
    int unsigned n;
    mismatches = 0;
    results_seen = 0;
    stim_done = 1'b0;
    in_valid_i = 1'b0;
    in_i = '0;
    rst_ni = 1'b0;
    foreach (op_hits[i]) op_hits[i] = 0;

    dir_rows.push_back(row(OP_ADD, 32'h7fff_ffff, 32'h1, 1, 32'h8000_0000, ST_OVF));
    dir_rows.push_back(row(OP_SUB, 32'h8000_0000, 32'h1, 1, 32'h7fff_ffff, ST_OVF));
    dir_rows.push_back(row(OP_MUL, 32'h200, 32'h300, 1, 32'h600, ST_OK));
    dir_rows.push_back(row(OP_MUL, 32'h7fff_ffff, 32'h7fff_ffff, 0, '0, ST_OK));
    dir_rows.push_back(row(OP_MUL, 32'h8000_0000, 32'hffff_ff00, 1, 32'h8000_0000, ST_OVF));
    dir_rows.push_back(row(OP_DIV, 32'h100, 32'h0, 1, 32'h0, ST_DIV0));
    dir_rows.push_back(row(OP_DIV, 32'h8000_0000, 32'h1, 0, '0, ST_OK));
    dir_rows.push_back(row(OP_DIV, 32'hffff_fd00, 32'h200, 1, 32'hffff_fe80, ST_OK));
    dir_rows.push_back(row(OP_DIV, 32'h8000_0000, 32'h8000_0000, 1, 32'h100, ST_OK));
    dir_rows.push_back(row(OP_GT, 32'h8000_0000, 32'h7fff_ffff, 1, 32'h0, ST_OK));
    dir_rows.push_back(row(OP_LT, 32'h8000_0000, 32'h7fff_ffff, 1, 32'h1, ST_OK));
    dir_rows.push_back(row(OP_GE, 32'h5, 32'h5, 1, 32'h1, ST_OK));
    dir_rows.push_back(row(OP_LE, 32'h6, 32'h5, 1, 32'h0, ST_OK));
    dir_rows.push_back(row(OP_EQ, 32'hffff_ffff, 32'hffff_ffff, 1, 32'h1, ST_OK));
    dir_rows.push_back(row(OP_NE, 32'h0, 32'h0, 1, 32'h0, ST_OK));
    dir_rows.push_back(row(OP_MIN, 32'h8000_0000, 32'h7fff_ffff, 1, 32'h8000_0000, ST_OK));
    dir_rows.push_back(row(OP_MAX, 32'h8000_0000, 32'h7fff_ffff, 1, 32'h7fff_ffff, ST_OK));
    dir_rows.push_back(row(OP_INC, 32'h7fff_ffff, 32'h0, 1, 32'h8000_0000, ST_OVF));
    dir_rows.push_back(row(OP_DEC, 32'h8000_0000, 32'h0, 1, 32'h7fff_ffff, ST_OVF));
    dir_rows.push_back(row(OP_FROM_INT, 32'h0080_0000, 32'h0, 1, 32'h8000_0000, ST_OVF));
    dir_rows.push_back(row(OP_TO_INT, 32'hffff_ff80, 32'h0, 1, 32'hffff_ffff, ST_OK));
    dir_rows.push_back(row(OP_FROM_FLOAT, 32'h7f80_0000, 32'h0, 1, 32'h7fff_ffff, ST_INV));
    dir_rows.push_back(row(OP_FROM_FLOAT, 32'hffc0_0000, 32'h0, 1, 32'h8000_0000, ST_INV));
    dir_rows.push_back(row(OP_FROM_FLOAT, 32'h3b80_0000, 32'h0, 0, '0, ST_OK));  // one LSB
    dir_rows.push_back(row(OP_TO_FLOAT, 32'h0, 32'h0, 1, 32'h0, ST_OK));
    dir_rows.push_back(row(OP_TO_FLOAT, 32'h8000_0000, 32'hffff_ffff, 1, 32'hcb00_0000, ST_OK));

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      known_flag_q.push_back(dir_rows[i].known);
      if (dir_rows[i].known) known_q.push_back(dir_rows[i].res);
      send(dir_rows[i].stim);
      if ($urandom_range(0, 2) == 0) gap();
    end

    n = 0;
    while (n < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        t.op = 5'($urandom_range(0, 17));
        if ($urandom_range(0, 30) == 0) t.op = 5'($urandom_range(18, 31));
        t.operand_a = (t.op == OP_FROM_FLOAT) ? rand_float() : rand_operand();
        t.operand_b = ($urandom_range(0, 20) == 0) ? 32'h0 : rand_operand();
        send(t);
        n++;
      end
      gap();
    end
    in_valid_i <= 1'b0;
    stim_done = 1'b1;

    while (alu_expected_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    $display("Ran %0d results: %0d directed rows, random ops across all 18 codes and unused ones.",
             results_seen, dir_rows.size());
    $display("Divides %0d, float conversions %0d/%0d, mismatches %0d.", op_hits[OP_DIV],
             op_hits[OP_FROM_FLOAT], op_hits[OP_TO_FLOAT], mismatches);
    if (mismatches == 0 && alu_expected_q.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
